[rtl/smsh_pkg.sv]
`timescale 1ns / 1ps

package smsh_pkg;

	localparam int unsigned DEF_NUM_BINS = 50;
	localparam int unsigned MAX_NUM_BINS = 256;
	// wide enough for the overflow bin at the largest bin count
	localparam int unsigned BIN_W        = $clog2(MAX_NUM_BINS + 2);

	localparam int unsigned MODE_W       = 2;
	localparam int unsigned PT_W         = 16;
	localparam int unsigned ETA_W        = 13;
	localparam int unsigned ETA_LIM_W    = 12;
	localparam int unsigned ISO_W        = 16;
	localparam int unsigned SHIFT_W      = 4;
	localparam int unsigned WS_W         = 2;
	localparam int unsigned IDX_W        = 6;
	localparam int unsigned TOTAL_W      = 32;
	localparam int unsigned WSUM_W       = 40;

	localparam int unsigned CFG_IDX_W    = 2;
	localparam int unsigned CFG_DATA_W   = 16;

	localparam int unsigned IN_TDATA_W   = 56;
	localparam int unsigned OUT_TDATA_W  = 80;

	localparam int unsigned QUEUE_DEPTH  = 4;

	localparam logic [PT_W-1:0]      PT_MIN_RST    = 16'd1600;
	localparam logic [ETA_LIM_W-1:0] ETA_LIMIT_RST = 12'd2458;
	localparam logic [ISO_W-1:0]     ISO_LIMIT_RST = 16'd123;
	localparam logic [SHIFT_W-1:0]   BIN_SHIFT_RST = 4'd8;

	typedef enum logic [MODE_W-1:0] {
		MODE_CAND  = 2'd0,
		MODE_EVENT = 2'd1,
		MODE_READ  = 2'd2
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PT_MIN    = 2'd0,
		REG_ETA_LIMIT = 2'd1,
		REG_ISO_LIMIT = 2'd2,
		REG_BIN_SHIFT = 2'd3
	} cfg_reg_t;

	typedef enum logic {
		OP_EVENT = 1'b0,
		OP_READ  = 1'b1
	} op_t;

	// input word, first member is the top bit
	typedef struct packed {
		logic                    pad;
		logic [IDX_W-1:0]        read_bin;
		logic [WS_W-1:0]         weight_sign;
		logic                    trigger;
		logic                    tight_id;
		logic [ISO_W-1:0]        iso;
		logic signed [ETA_W-1:0] eta;
		logic [PT_W-1:0]         pt;
	} in_word_t;

	typedef struct packed {
		logic [1:0]                pad;
		logic signed [WSUM_W-1:0]  weight_total;
		logic signed [TOTAL_W-1:0] bin_total;
		logic [IDX_W-1:0]          bin_index;
	} out_word_t;

	// work handed from the front to the back
	typedef struct packed {
		op_t              op;
		logic             hit;    // fill accepted, or read in range
		logic [BIN_W-1:0] bin;
		logic [IDX_W-1:0] idx;
		logic [WS_W-1:0]  wsign;
	} cmd_t;

endpackage

[rtl/smsh_front.sv]
`timescale 1ns / 1ps

module smsh_front #(
	parameter int unsigned NUM_BINS = smsh_pkg::DEF_NUM_BINS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [smsh_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [smsh_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [smsh_pkg::IN_TDATA_W-1:0] s_tdata,
	input  logic [smsh_pkg::MODE_W-1:0]     s_tuser,
	output smsh_pkg::cmd_t                  cmd,
	output logic                            cmd_push,
	input  logic                            cmd_full
);
	import smsh_pkg::*;

	localparam logic [BIN_W-1:0] OVF_BIN     = BIN_W'(NUM_BINS + 1);
	localparam logic [PT_W:0]    NUM_BINS_PT = (PT_W + 1)'(NUM_BINS);

	logic [PT_W-1:0]      pt_min_q;
	logic [ETA_LIM_W-1:0] eta_limit_q;
	logic [ISO_W-1:0]     iso_limit_q;
	logic [SHIFT_W-1:0]   bin_shift_q;
	logic [1:0]           pass_count_q;
	logic [PT_W-1:0]      chosen_pt_q;

	in_word_t         in_w;
	mode_t            mode;
	logic             take;
	logic [ETA_W-1:0] abs_eta;
	logic             pass;
	logic [PT_W:0]    pt_shifted;
	logic [BIN_W-1:0] fill_bin;

	assign in_w     = in_word_t'(s_tdata);
	assign mode     = mode_t'(s_tuser);
	assign s_tready = !cmd_full;
	assign take     = s_tvalid && s_tready;

	assign abs_eta = in_w.eta[ETA_W-1] ? ETA_W'(-in_w.eta) : ETA_W'(in_w.eta);
	assign pass    = (in_w.pt > pt_min_q) && (abs_eta < {1'b0, eta_limit_q})
		&& (in_w.iso < iso_limit_q) && in_w.tight_id;

	// bin of the kept pt, folded into the overflow bin past the last regular one
	assign pt_shifted = {1'b0, chosen_pt_q} >> bin_shift_q;
	assign fill_bin   = (pt_shifted >= NUM_BINS_PT) ? OVF_BIN
		: BIN_W'(pt_shifted) + BIN_W'(1);

	always_comb begin
		cmd.op    = (mode == MODE_READ) ? OP_READ : OP_EVENT;
		cmd.wsign = in_w.weight_sign;
		if (mode == MODE_READ) begin
			cmd.hit = (32'(in_w.read_bin) < NUM_BINS + 2);
			cmd.bin = BIN_W'(in_w.read_bin);
			cmd.idx = in_w.read_bin;
		end else begin
			cmd.hit = (pass_count_q == 2'd1) && in_w.trigger;
			cmd.bin = fill_bin;
			cmd.idx = fill_bin[IDX_W-1:0];
		end
	end

	assign cmd_push = take && ((mode == MODE_EVENT) || (mode == MODE_READ));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pt_min_q     <= PT_MIN_RST;
			eta_limit_q  <= ETA_LIMIT_RST;
			iso_limit_q  <= ISO_LIMIT_RST;
			bin_shift_q  <= BIN_SHIFT_RST;
			pass_count_q <= 2'd0;
			chosen_pt_q  <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_PT_MIN:    pt_min_q    <= cfg_data[PT_W-1:0];
					REG_ETA_LIMIT: eta_limit_q <= cfg_data[ETA_LIM_W-1:0];
					REG_ISO_LIMIT: iso_limit_q <= cfg_data[ISO_W-1:0];
					REG_BIN_SHIFT: bin_shift_q <= cfg_data[SHIFT_W-1:0];
					default: ;
				endcase
			end
			if (take) begin
				case (mode)
					MODE_CAND: begin
						if (pass) begin
							if (pass_count_q != 2'd2) begin
								pass_count_q <= pass_count_q + 2'd1;
							end
							chosen_pt_q <= in_w.pt;
						end
					end
					MODE_EVENT: begin
						pass_count_q <= 2'd0;
						chosen_pt_q  <= '0;
					end
					default: ;
				endcase
			end
		end
	end

	a_pass_count_sat: assert property (@(posedge clk) disable iff (!arst_n)
		pass_count_q != 2'd3)
		else $error("pass count ran past saturation");

	a_event_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(take && mode == MODE_EVENT) |=> (pass_count_q == 2'd0 && chosen_pt_q == '0))
		else $error("event state not cleared at end of event");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push |-> !cmd_full)
		else $error("push into a full queue");

endmodule

[rtl/smsh_fifo.sv]
`timescale 1ns / 1ps

module smsh_fifo #(
	parameter int unsigned DEPTH = smsh_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  smsh_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output smsh_pkg::cmd_t pop_cmd,
	output logic           empty
);
	import smsh_pkg::*;

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

	cmd_t          slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign pop_cmd = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count beyond depth");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from an empty queue");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into a full queue");

endmodule

[rtl/smsh_back.sv]
`timescale 1ns / 1ps

module smsh_back #(
	parameter int unsigned NUM_BINS = smsh_pkg::DEF_NUM_BINS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  smsh_pkg::cmd_t                   head,
	input  logic                             empty,
	output logic                             pop,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [smsh_pkg::OUT_TDATA_W-1:0] m_tdata,
	output logic [0:0]                       m_tuser
);
	import smsh_pkg::*;

	localparam int unsigned TOTAL_BINS = NUM_BINS + 2;
	localparam int unsigned AW         = $clog2(TOTAL_BINS);
	localparam logic signed [TOTAL_W-1:0] TOT_MAX = {1'b0, {(TOTAL_W-1){1'b1}}};
	localparam logic signed [TOTAL_W-1:0] TOT_MIN = {1'b1, {(TOTAL_W-1){1'b0}}};
	localparam logic signed [WSUM_W-1:0]  WS_MAX  = {1'b0, {(WSUM_W-1){1'b1}}};
	localparam logic signed [WSUM_W-1:0]  WS_MIN  = {1'b1, {(WSUM_W-1){1'b0}}};

	logic signed [TOTAL_W-1:0] mem [TOTAL_BINS];
	logic [TOTAL_BINS-1:0]     bin_valid_q;

	cmd_t                      s1_q;
	logic                      s1_vld_q;
	logic signed [TOTAL_W-1:0] rd_s1;
	logic                      rdv_s1;
	logic                      fwd_s1;
	logic signed [TOTAL_W-1:0] fwd_val_s1;

	logic signed [WSUM_W-1:0]  wsum_q;
	logic                      m_tvalid_q;
	logic                      out_acc_q;
	logic [IDX_W-1:0]          out_idx_q;
	logic signed [TOTAL_W-1:0] out_total_q;
	logic signed [WSUM_W-1:0]  out_wsum_q;

	logic                      adv;
	logic [AW-1:0]             head_addr;
	logic [AW-1:0]             s1_addr;
	logic signed [TOTAL_W-1:0] base;
	logic signed [TOTAL_W-1:0] new_total;
	logic signed [WSUM_W-1:0]  wsum_next;
	logic                      w_pos;
	logic                      w_neg;
	logic                      is_event;
	logic                      wr_en;
	out_word_t                 out_w;

	// output register frees up when empty or being taken
	assign adv       = !m_tvalid_q || m_tready;
	assign pop       = adv && !empty;
	assign head_addr = head.bin[AW-1:0];
	assign s1_addr   = s1_q.bin[AW-1:0];

	assign w_pos    = (s1_q.wsign == 2'b01);
	assign w_neg    = s1_q.wsign[1];
	assign is_event = (s1_q.op == OP_EVENT);
	assign wr_en    = adv && s1_vld_q && is_event && s1_q.hit;

	// bin written on the previous edge is not yet in the read data
	assign base = fwd_s1 ? fwd_val_s1 : (rdv_s1 ? rd_s1 : '0);

	always_comb begin
		new_total = base;
		if (w_pos && base != TOT_MAX) begin
			new_total = base + TOTAL_W'(1);
		end else if (w_neg && base != TOT_MIN) begin
			new_total = base - TOTAL_W'(1);
		end
		wsum_next = wsum_q;
		if (is_event) begin
			if (w_pos && wsum_q != WS_MAX) begin
				wsum_next = wsum_q + WSUM_W'(1);
			end else if (w_neg && wsum_q != WS_MIN) begin
				wsum_next = wsum_q - WSUM_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rd_s1 <= mem[head_addr];
		end
		if (wr_en) begin
			mem[s1_addr] <= new_total;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			s1_q       <= head;
			rdv_s1     <= bin_valid_q[head_addr];
			fwd_val_s1 <= new_total;
		end
		if (adv && s1_vld_q) begin
			out_acc_q   <= is_event && s1_q.hit;
			out_idx_q   <= (is_event && !s1_q.hit) ? '0 : s1_q.idx;
			out_total_q <= !s1_q.hit ? '0 : (is_event ? new_total : base);
			out_wsum_q  <= wsum_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_valid_q <= '0;
			s1_vld_q    <= 1'b0;
			fwd_s1      <= 1'b0;
			wsum_q      <= '0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				bin_valid_q[s1_addr] <= 1'b1;
			end
			if (adv) begin
				s1_vld_q   <= !empty;
				fwd_s1     <= pop && wr_en && (s1_q.bin == head.bin);
				m_tvalid_q <= s1_vld_q;
				if (s1_vld_q) begin
					wsum_q <= wsum_next;
				end
			end
		end
	end

	always_comb begin
		out_w              = '0;
		out_w.bin_index    = out_idx_q;
		out_w.bin_total    = out_total_q;
		out_w.weight_total = out_wsum_q;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_w;
	assign m_tuser  = out_acc_q;

	a_wsum_step: assert property (@(posedge clk) disable iff (!arst_n)
		(wsum_q != $past(wsum_q)) |-> $past(adv && s1_vld_q && is_event))
		else $error("weight sum moved without an event word");

	a_fwd_live: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_s1 |-> s1_vld_q)
		else $error("forwarding flag set with no word in flight");

	a_read_not_acc: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && s1_vld_q && !is_event) |=> !out_acc_q)
		else $error("read word flagged as accepted event");

endmodule

[rtl/single_muon_select_histogram.sv]
`timescale 1ns / 1ps

// Single-muon selection with a weighted pt histogram. Candidate words (tuser 0)
// are cut on pt, |eta|, isolation and tight id; an end-of-event word (tuser 1)
// adds the weight sign to the running sum and, when exactly one candidate
// passed and the trigger bit is set, adds it to that candidate's pt bin; a read
// word (tuser 2) returns one bin. Event and read words each give one output
// word, candidates none. The block takes one word per cycle while the queue is
// not full: the front classifies and bins, a four-entry queue decouples it from
// the back, which does the bin read-modify-write on a one-read one-write memory
// with the read registered and one-deep forwarding, so back-to-back fills of
// the same bin do not stall. Bins clear at reset through per-bin valid flags,
// so no clearing pass is needed. The user must write configuration while
// idle; the block itself does not enforce it.
module single_muon_select_histogram #(
	parameter int unsigned NUM_BINS = smsh_pkg::DEF_NUM_BINS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [smsh_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [smsh_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// pt[15:0], eta[28:16], iso[44:29], tight_id[45], trigger[46],
	// weight_sign[48:47], read_bin[54:49], zero[55]
	input  logic [smsh_pkg::IN_TDATA_W-1:0]  s_tdata,
	// mode[1:0]
	input  logic [smsh_pkg::MODE_W-1:0]      s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// bin_index[5:0], bin_total[37:6], weight_total[77:38], zero[79:78]
	output logic [smsh_pkg::OUT_TDATA_W-1:0] m_tdata,
	// event_accepted[0]
	output logic [0:0]                       m_tuser
);
	import smsh_pkg::*;

	cmd_t push_cmd;
	cmd_t head_cmd;
	logic push;
	logic full;
	logic pop;
	logic empty;

	smsh_front #(
		.NUM_BINS (NUM_BINS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cmd       (push_cmd),
		.cmd_push  (push),
		.cmd_full  (full)
	);

	smsh_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (full),
		.pop      (pop),
		.pop_cmd  (head_cmd),
		.empty    (empty)
	);

	smsh_back #(
		.NUM_BINS (NUM_BINS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head_cmd),
		.empty    (empty),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule
